// ===== src/djq_pkg.sv =====
package djq_pkg;

	localparam int TIME_W = 48;
	localparam int DELAY_W = 32;
	localparam int ROOM_W = 32;
	localparam int HANDLE_W = 16;
	localparam int MAX_RESULTS = 32;
	localparam int CMD_QUEUE_DEPTH = 2;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_DUE = 2'd0,
		KIND_FULL = 2'd1,
		KIND_CANCEL = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_INSERT,
		BK_EMIT
	} back_state_t;

	// For an add, tick holds the computed deadline; otherwise it holds now.
	typedef struct packed {
		opcode_t op;
		logic [TIME_W-1:0] tick;
		logic [ROOM_W-1:0] room;
		logic [HANDLE_W-1:0] handle;
	} cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [ROOM_W-1:0] room;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		logic valid;
		kind_t kind;
		entry_t entry;
		logic last;
	} result_t;

endpackage

// ===== src/deadline_ordered_job_queue_top.sv =====
// An accepted word is written into the command queue, popped into the back end's command register once
// the back end is idle, and its first result is then registered on the outputs. An add takes a fetch and
// an insert state; a release or clear is fetched, then emits one entry per cycle, or makes one check if none is due.
// A two-word command queue lets the front accept while the back is still working.
// Reset: arst_n empties the job queue and command queue; stored entries are undefined.
// The receiver cannot stall, so each result stands for one cycle with strobe high.
module deadline_ordered_job_queue_top #(
	parameter int QUEUE_DEPTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] opcode,
	input logic [djq_pkg::TIME_W-1:0] now,
	input logic [djq_pkg::DELAY_W-1:0] delay,
	input logic [djq_pkg::ROOM_W-1:0] room_id,
	input logic [djq_pkg::HANDLE_W-1:0] job_handle,
	output logic strobe,
	output logic [1:0] kind,
	output logic [djq_pkg::ROOM_W-1:0] room_id_out,
	output logic [djq_pkg::HANDLE_W-1:0] job_handle_out,
	output logic [djq_pkg::TIME_W-1:0] deadline_out,
	output logic last
);
	import djq_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	result_t result;
	logic push;
	logic pop;
	logic q_empty;
	logic q_full;

	djq_front u_front (
		.start(start),
		.opcode(opcode),
		.now(now),
		.delay(delay),
		.room_id(room_id),
		.job_handle(job_handle),
		.queue_full(q_full),
		.busy(busy),
		.push(push),
		.cmd(front_cmd)
	);

	djq_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_cmd(front_cmd),
		.pop(pop),
		.rd_cmd(head_cmd),
		.empty(q_empty),
		.full(q_full)
	);

	djq_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_avail(!q_empty),
		.cmd(head_cmd),
		.cmd_pop(pop),
		.result(result)
	);

	assign strobe = result.valid;
	assign kind = result.kind;
	assign room_id_out = result.entry.room;
	assign job_handle_out = result.entry.handle;
	assign deadline_out = result.entry.deadline;
	assign last = result.last;

endmodule

// ===== src/djq_front.sv =====
module djq_front (
	input logic start,
	input logic [1:0] opcode,
	input logic [djq_pkg::TIME_W-1:0] now,
	input logic [djq_pkg::DELAY_W-1:0] delay,
	input logic [djq_pkg::ROOM_W-1:0] room_id,
	input logic [djq_pkg::HANDLE_W-1:0] job_handle,
	input logic queue_full,
	output logic busy,
	output logic push,
	output djq_pkg::cmd_t cmd
);
	import djq_pkg::*;

	logic [TIME_W:0] sum;
	logic [TIME_W-1:0] deadline;
	logic known_op;

	assign sum = {1'b0, now} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay};
	assign deadline = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

	always_comb begin
		known_op = 1'b0;
		cmd.op = OP_ADD;
		cmd.tick = now;
		cmd.room = room_id;
		cmd.handle = job_handle;
		unique case (opcode)
			OP_ADD: begin
				known_op = 1'b1;
				cmd.op = OP_ADD;
				cmd.tick = deadline;
			end
			OP_RELEASE: begin
				known_op = 1'b1;
				cmd.op = OP_RELEASE;
			end
			OP_CLEAR: begin
				known_op = 1'b1;
				cmd.op = OP_CLEAR;
			end
			default: begin
				known_op = 1'b0;
			end
		endcase
	end

	assign busy = queue_full;
	assign push = start && !queue_full && known_op;

endmodule

// ===== src/djq_fifo.sv =====
module djq_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input djq_pkg::cmd_t wr_cmd,
	input logic pop,
	output djq_pkg::cmd_t rd_cmd,
	output logic empty,
	output logic full
);
	import djq_pkg::*;

	localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(CMD_QUEUE_DEPTH + 1);

	cmd_t slot_q [CMD_QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [FW-1:0] fill_q;
	logic do_push;
	logic do_pop;

	assign empty = (fill_q == '0);
	assign full = (fill_q == FW'(CMD_QUEUE_DEPTH));
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

// ===== src/djq_back.sv =====
module djq_back #(
	parameter int QUEUE_DEPTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_avail,
	input djq_pkg::cmd_t cmd,
	output logic cmd_pop,
	output djq_pkg::result_t result
);
	import djq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = $clog2(MAX_RESULTS);

	back_state_t state_q;
	back_state_t state_d;
	cmd_t cur_q;
	entry_t cell_q [QUEUE_DEPTH];
	entry_t new_entry;
	logic [CW-1:0] count_q;
	logic [NW-1:0] sent_q;
	logic [QUEUE_DEPTH-1:0] ins;
	logic is_clear;
	logic full;
	logic due;
	logic do_insert;
	logic do_shift;
	logic emit;
	logic emit_last;
	kind_t emit_kind;
	entry_t emit_entry;

	assign new_entry = '{deadline: cur_q.tick, room: cur_q.room, handle: cur_q.handle};
	assign is_clear = (cur_q.op == OP_CLEAR);
	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign due = (count_q != '0) && (is_clear || (cell_q[0].deadline <= cur_q.tick));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		do_insert = 1'b0;
		do_shift = 1'b0;
		emit = 1'b0;
		emit_last = 1'b0;
		emit_kind = KIND_DUE;
		emit_entry = cell_q[0];
		unique case (state_q)
			BK_IDLE: begin
				cmd_pop = cmd_avail;
				if (cmd_avail) begin
					state_d = (cmd.op == OP_ADD) ? BK_INSERT : BK_EMIT;
				end
			end
			BK_INSERT: begin
				state_d = BK_IDLE;
				if (full) begin
					emit = 1'b1;
					emit_last = 1'b1;
					emit_kind = KIND_FULL;
					emit_entry = new_entry;
				end else begin
					do_insert = 1'b1;
				end
			end
			BK_EMIT: begin
				state_d = BK_IDLE;
				if (due) begin
					emit = 1'b1;
					do_shift = 1'b1;
					emit_kind = is_clear ? KIND_CANCEL : KIND_DUE;
					emit_last = (count_q == CW'(1)) || (sent_q == NW'(MAX_RESULTS - 1)) ||
						(!is_clear && (cell_q[1].deadline > cur_q.tick));
					if (!emit_last) begin
						state_d = BK_EMIT;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sent_q <= '0;
			result <= '0;
		end else begin
			if (do_insert) begin
				count_q <= count_q + 1'b1;
			end else if (do_shift) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd_pop) begin
				sent_q <= '0;
			end else if (do_shift) begin
				sent_q <= sent_q + 1'b1;
			end
			result.valid <= emit;
			if (emit) begin
				result.kind <= emit_kind;
				result.entry <= emit_entry;
				result.last <= emit_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
	end

	// A cell takes the new entry, or its upper neighbor, when the new deadline is earlier
	// than its own or the cell is the first free one; each emitted entry moves all cells to the front.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t up;
		entry_t down;
		logic from_up;

		if (i == 0) begin : g_first
			assign up = new_entry;
			assign from_up = 1'b0;
		end else begin : g_inner
			assign up = cell_q[i-1];
			assign from_up = ins[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_end
			assign down = cell_q[i];
		end else begin : g_next
			assign down = cell_q[i+1];
		end

		assign ins[i] = (CW'(i) < count_q) ? (cell_q[i].deadline > cur_q.tick) :
			(CW'(i) == count_q);

		always_ff @(posedge clk) begin
			if (do_insert && ins[i]) begin
				cell_q[i] <= from_up ? up : new_entry;
			end else if (do_shift) begin
				cell_q[i] <= down;
			end
		end
	end

endmodule

// ===== sim/deadline_ordered_job_queue_top_tb.sv =====
`timescale 1ns / 100ps

module deadline_ordered_job_queue_top_tb;
	import djq_pkg::*;

	localparam int DEPTH = 32;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 200;
	localparam int CALM_TAIL = 30;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [1:0] op;
		logic [TIME_W-1:0] tick;
		logic [DELAY_W-1:0] delay;
		logic [ROOM_W-1:0] room;
		logic [HANDLE_W-1:0] handle;
	} job_word_t;

	typedef struct packed {
		kind_t kind;
		entry_t ent;
		logic last;
	} job_result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] opcode;
	logic [TIME_W-1:0] now;
	logic [DELAY_W-1:0] delay;
	logic [ROOM_W-1:0] room_id;
	logic [HANDLE_W-1:0] job_handle;
	logic strobe;
	logic [1:0] kind;
	logic [ROOM_W-1:0] room_id_out;
	logic [HANDLE_W-1:0] job_handle_out;
	logic [TIME_W-1:0] deadline_out;
	logic last;

	job_word_t cur_word;
	job_word_t next_word;
	job_word_t pending_words[$];
	entry_t held_jobs[$];
	job_result_t awaited_results[$];
	job_result_t got_result;

	logic word_taken = 1'b0;
	int idle_left = 0;
	int words_sent = 0;
	int mismatches = 0;
	int adds_stored = 0;
	int adds_rejected = 0;
	int releases_seen = 0;
	int clears_seen = 0;
	int results_checked = 0;

	logic [TIME_W-1:0] clock_ms;
	int directed_words;
	int fills;
	int seg;
	int k;
	int m;

	assign opcode = cur_word.op;
	assign now = cur_word.tick;
	assign delay = cur_word.delay;
	assign room_id = cur_word.room;
	assign job_handle = cur_word.handle;

	deadline_ordered_job_queue_top #(
		.QUEUE_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.now(now),
		.delay(delay),
		.room_id(room_id),
		.job_handle(job_handle),
		.strobe(strobe),
		.kind(kind),
		.room_id_out(room_id_out),
		.job_handle_out(job_handle_out),
		.deadline_out(deadline_out),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [TIME_W-1:0] saturated_sum(logic [TIME_W-1:0] a,
			logic [DELAY_W-1:0] b);
		logic [TIME_W:0] sum;
		sum = {1'b0, a} + {{(TIME_W + 1 - DELAY_W){1'b0}}, b};
		return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] random_tick();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[TIME_W-1:0];
	endfunction

	function automatic void add_word(logic [1:0] op, logic [TIME_W-1:0] tick,
			logic [DELAY_W-1:0] dly, logic [ROOM_W-1:0] room, logic [HANDLE_W-1:0] handle);
		job_word_t w;
		w.op = op;
		w.tick = tick;
		w.delay = dly;
		w.room = room;
		w.handle = handle;
		pending_words.insert(pending_words.size(), w);
	endfunction

	function automatic void apply_job_word(job_word_t w);
		entry_t e;
		job_result_t r;
		int pos;
		int n;
		int i;
		case (w.op)
		OP_ADD: begin
			e.deadline = saturated_sum(w.tick, w.delay);
			e.room = w.room;
			e.handle = w.handle;
			if (held_jobs.size() >= DEPTH) begin
				r.kind = KIND_FULL;
				r.ent = e;
				r.last = 1'b1;
				awaited_results.insert(awaited_results.size(), r);
				adds_rejected++;
			end else begin
				pos = held_jobs.size();
				while (pos > 0 && held_jobs[pos-1].deadline > e.deadline)
					pos--;
				held_jobs.insert(pos, e);
				adds_stored++;
			end
		end
		OP_RELEASE, OP_CLEAR: begin
			if (w.op == OP_CLEAR)
				clears_seen++;
			else
				releases_seen++;
			n = 0;
			while (n < held_jobs.size() && n < MAX_RESULTS &&
					(w.op == OP_CLEAR || held_jobs[n].deadline <= w.tick))
				n++;
			for (i = 0; i < n; i++) begin
				r.kind = (w.op == OP_CLEAR) ? KIND_CANCEL : KIND_DUE;
				r.ent = held_jobs.pop_front();
				r.last = (i == n - 1);
				awaited_results.insert(awaited_results.size(), r);
			end
		end
		default: begin
		end
		endcase
	endfunction

	function automatic void check_field(string field, logic [TIME_W-1:0] want,
			logic [TIME_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		word_taken = arst_n && start && !busy;
		if (word_taken)
			apply_job_word(cur_word);
		if (arst_n && strobe) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d room %h",
					$time, kind, room_id_out);
				$display("    handle %h deadline %h last %b",
					job_handle_out, deadline_out, last);
				mismatches++;
			end else begin
				got_result = awaited_results.pop_front();
				check_field("kind", TIME_W'(got_result.kind), TIME_W'(kind));
				check_field("room_id_out", TIME_W'(got_result.ent.room),
					TIME_W'(room_id_out));
				check_field("job_handle_out", TIME_W'(got_result.ent.handle),
					TIME_W'(job_handle_out));
				check_field("deadline_out", got_result.ent.deadline, deadline_out);
				check_field("last", TIME_W'(got_result.last), TIME_W'(last));
				results_checked++;
			end
		end
	end

	// A word stays on the inputs until it is taken; gaps are only opened after a word.
	always @(negedge clk) begin
		if (arst_n && !(start && !word_taken)) begin
			if (idle_left > 0) begin
				idle_left = idle_left - 1;
				start <= 1'b0;
			end else if (pending_words.size() > 0) begin
				next_word = pending_words.pop_front();
				cur_word <= next_word;
				start <= 1'b1;
				words_sent++;
				if (pending_words.size() >= CALM_TAIL && (words_sent % 64) < 40 &&
						$urandom_range(0, 2) == 0)
					idle_left = $urandom_range(1, 13);
			end else begin
				start <= 1'b0;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cur_word = '0;

		add_word(OP_RELEASE, TIME_MAX, '0, '0, '0);
		add_word(OP_CLEAR, '0, '0, '0, '0);
		add_word(OP_UNUSED, random_tick(), $urandom(), $urandom(), HANDLE_W'($urandom()));
		add_word(OP_ADD, '0, '0, '0, '0);
		add_word(OP_ADD, TIME_MAX, '1, '1, '1);
		add_word(OP_ADD, TIME_MAX - 10, 32'd10, 32'h1234_5678, 16'h00a5);
		add_word(OP_ADD, 48'd100, 32'd50, 32'h0000_0a0a, 16'd1);
		add_word(OP_ADD, 48'd120, 32'd30, 32'h0000_0b0b, 16'd2);
		add_word(OP_ADD, 48'd0, 32'd149, 32'h0000_0c0c, 16'd3);
		add_word(OP_ADD, 48'd1000, 32'd0, 32'h0000_0d0d, 16'd4);
		add_word(OP_RELEASE, 48'd0, '1, '1, '1);
		add_word(OP_RELEASE, 48'd149, '0, '0, '0);
		add_word(OP_RELEASE, 48'd150, '0, '0, '0);
		add_word(OP_RELEASE, 48'd999, '0, '0, '0);
		add_word(OP_RELEASE, TIME_MAX - 1, '0, '0, '0);
		add_word(OP_UNUSED, TIME_MAX, '1, '1, '1);
		add_word(OP_RELEASE, TIME_MAX, '0, '0, '0);
		add_word(OP_ADD, 48'd5, 32'd5, 32'hffff_0000, 16'hff00);
		add_word(OP_ADD, 48'd7, 32'd0, 32'h0000_ffff, 16'h00ff);
		add_word(OP_CLEAR, '0, '0, '0, '0);
		directed_words = pending_words.size();

		clock_ms = 48'd5000;
		fills = 0;
		while (pending_words.size() < directed_words + RANDOM_WORDS) begin
			seg = $urandom_range(0, 9);
			if (fills == 0 && pending_words.size() >= 90)
				seg = 0;
			if (seg == 0 && fills < 2) begin
				fills++;
				for (k = 0; k < DEPTH + 2; k++)
					add_word(OP_ADD, clock_ms, $urandom_range(0, 5000), $urandom(),
						HANDLE_W'($urandom()));
				add_word(OP_RELEASE, saturated_sum(clock_ms, 2500), '0, '0, '0);
				add_word(OP_CLEAR, random_tick(), $urandom(), $urandom(),
					HANDLE_W'($urandom()));
			end else if (seg == 1) begin
				m = $urandom_range(1, 6);
				for (k = 0; k < m; k++)
					add_word(2'($urandom_range(0, 3)), random_tick(), $urandom(), $urandom(),
						HANDLE_W'($urandom()));
			end else if (seg == 2) begin
				add_word(OP_CLEAR, clock_ms, '0, '0, '0);
			end else begin
				case ($urandom_range(0, 7))
				0: clock_ms = random_tick();
				1: clock_ms = TIME_MAX - $urandom_range(0, 3000);
				default: clock_ms = saturated_sum(clock_ms, $urandom_range(0, 3000));
				endcase
				m = $urandom_range(1, 10);
				for (k = 0; k < m; k++)
					add_word(OP_ADD, clock_ms,
						($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 2000),
						$urandom(), HANDLE_W'($urandom()));
				add_word(OP_RELEASE, saturated_sum(clock_ms, $urandom_range(0, 2500)),
					'0, '0, '0);
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() > 0 || start)
			@(posedge clk);
		while (awaited_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d words: %0d adds stored, %0d adds rejected as full,",
			words_sent, adds_stored, adds_rejected);
		$display("%0d releases and %0d clears; checked %0d results with %0d mismatches.",
			releases_seen, clears_seen, results_checked, mismatches);
		if (mismatches == 0)
			$display("deadline_ordered_job_queue_top_tb passed");
		else
			$display("deadline_ordered_job_queue_top_tb failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d words pending and %0d results outstanding.",
			pending_words.size(), awaited_results.size());
		$display("deadline_ordered_job_queue_top_tb failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/djq_pkg.sv
src/djq_front.sv
src/djq_fifo.sv
src/djq_back.sv
src/deadline_ordered_job_queue_top.sv
sim/deadline_ordered_job_queue_top_tb.sv
